[design/tapv_pkg.sv]
// Shared types, widths and constants of the three-axis PID velocity block.
package tapv_pkg;

    localparam int AXES = 3;

    localparam int ERR_W  = 32;
    localparam int GAIN_W = 24;
    localparam int DT_W   = 20;
    localparam int SUM_W  = 48;
    localparam int TOT_W  = 64;
    localparam int VEL_W  = 32;

    localparam int MC_W = 57;
    localparam int ML_W = GAIN_W;
    localparam int PR_W = 77;
    localparam int DV_W = 68;
    localparam int DS_W = DT_W;

    localparam int MUL_STEPS = ML_W;
    localparam int DIV_STEPS = DV_W;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    localparam logic [DS_W-1:0] MICRO = DS_W'(1000000);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV = 2'd2;

    localparam logic [GAIN_W-1:0] KP_RESET = GAIN_W'(589824);
    localparam logic [GAIN_W-1:0] KI_RESET = GAIN_W'(0);
    localparam logic [GAIN_W-1:0] KD_RESET = GAIN_W'(13107);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_MUL_P  = 9'b000000010,
        ST_MUL_IS = 9'b000000100,
        ST_DIV_I  = 9'b000001000,
        ST_MUL_IK = 9'b000010000,
        ST_MUL_DK = 9'b000100000,
        ST_MUL_DM = 9'b001000000,
        ST_DIV_D  = 9'b010000000,
        ST_FIN    = 9'b100000000
    } t_state;

    typedef struct packed {
        t_state state;
        logic   take;
        logic   mul_load;
        logic   mul_step;
        logic   div_load;
        logic   div_step;
    } t_ctrl;

endpackage

[design/tapv_mul.sv]
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle while i_step is high.
module tapv_mul
    import tapv_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_load,
    input  logic            i_step,
    input  logic [MC_W-1:0] i_mcand,
    input  logic [ML_W-1:0] i_mplr,
    output logic [PR_W-1:0] o_prod
);

    logic [PR_W-1:0] r_acc;
    logic [PR_W-1:0] r_mcand;
    logic [ML_W-1:0] r_mplr;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_acc   <= '0;
            r_mcand <= PR_W'(i_mcand);
            r_mplr  <= i_mplr;
        end else if (i_step) begin
            if (r_mplr[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand <= r_mcand << 1;
            r_mplr  <= r_mplr >> 1;
        end
    end

    assign o_prod = r_acc;

endmodule

[design/tapv_div.sv]
// Restoring divider that produces one quotient bit per cycle while i_step is high.
module tapv_div
    import tapv_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_load,
    input  logic            i_step,
    input  logic [DV_W-1:0] i_dvd,
    input  logic [DS_W-1:0] i_dvsr,
    output logic [DV_W-1:0] o_quot
);

    logic [DV_W-1:0] r_q;
    logic [DS_W-1:0] r_rem;
    logic [DS_W-1:0] r_dvsr;
    logic [DS_W:0]   w_rem_sh;
    logic [DS_W:0]   w_diff;
    logic            w_ge;
    logic [DS_W-1:0] n_rem;

    always_comb begin
        w_rem_sh = {r_rem, r_q[DV_W-1]};
        w_diff   = w_rem_sh - {1'b0, r_dvsr};
        w_ge     = (w_rem_sh >= {1'b0, r_dvsr});
        n_rem    = w_ge ? w_diff[DS_W-1:0] : w_rem_sh[DS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q    <= i_dvd;
            r_rem  <= '0;
            r_dvsr <= i_dvsr;
        end else if (i_step) begin
            r_q   <= {r_q[DV_W-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    assign o_quot = r_q;

endmodule

[design/tapv_lane.sv]
// One axis: running error sum, serial multiplier and divider, and term accumulation.
module tapv_lane
    import tapv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl             i_ctrl,
    input  logic [GAIN_W-1:0] i_kp,
    input  logic [GAIN_W-1:0] i_ki,
    input  logic [GAIN_W-1:0] i_kd,
    input  logic [DT_W-1:0]   i_dt,
    input  logic [ERR_W-1:0]  i_err,
    input  logic [ERR_W-1:0]  i_prev_err,
    output logic [VEL_W-1:0]  o_vel
);

    logic [SUM_W-1:0] r_sum;
    logic [ERR_W-1:0] r_mag_e;
    logic             r_neg_e;
    logic [ERR_W:0]   r_mag_d;
    logic             r_neg_d;
    logic [SUM_W-1:0] r_mag_s;
    logic             r_neg_s;
    logic [TOT_W-1:0] r_total;

    logic [SUM_W:0]   w_s_wide;
    logic [SUM_W-1:0] w_s_sat;
    logic [ERR_W:0]   w_d;
    logic [MC_W-1:0]  w_mcand;
    logic [ML_W-1:0]  w_mplr;
    logic [DV_W-1:0]  w_dvd;
    logic [DS_W-1:0]  w_dvsr;
    logic [PR_W-1:0]  w_prod;
    logic [DV_W-1:0]  w_quot;
    logic [TOT_W-1:0] w_term_p;
    logic [TOT_W-1:0] w_term_i;
    logic [TOT_W-1:0] w_term_d;
    logic [TOT_W-1:0] w_sum_all;

    always_comb begin
        w_s_wide = {r_sum[SUM_W-1], r_sum}
                 + {{(SUM_W-ERR_W+1){i_err[ERR_W-1]}}, i_err};
        if (w_s_wide[SUM_W] != w_s_wide[SUM_W-1]) begin
            w_s_sat = w_s_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                      : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            w_s_sat = w_s_wide[SUM_W-1:0];
        end
        w_d = {i_err[ERR_W-1], i_err} - {i_prev_err[ERR_W-1], i_prev_err};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctrl.take) begin
            r_sum <= w_s_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.take) begin
            r_neg_e <= i_err[ERR_W-1];
            r_mag_e <= i_err[ERR_W-1] ? (~i_err + ERR_W'(1)) : i_err;
            r_neg_d <= w_d[ERR_W];
            r_mag_d <= w_d[ERR_W] ? (~w_d + (ERR_W+1)'(1)) : w_d;
            r_neg_s <= w_s_sat[SUM_W-1];
            r_mag_s <= w_s_sat[SUM_W-1] ? (~w_s_sat + SUM_W'(1)) : w_s_sat;
        end
    end

    always_comb begin
        w_mcand = '0;
        w_mplr  = '0;
        w_dvd   = '0;
        w_dvsr  = '0;
        unique case (i_ctrl.state) inside
            ST_MUL_P: begin
                w_mcand = MC_W'(r_mag_e);
                w_mplr  = i_kp;
            end
            ST_MUL_IS: begin
                w_mcand = MC_W'(r_mag_s);
                w_mplr  = ML_W'(i_dt);
            end
            ST_DIV_I: begin
                w_dvd  = w_prod[DV_W-1:0];
                w_dvsr = MICRO;
            end
            ST_MUL_IK: begin
                w_mcand = MC_W'(w_quot[SUM_W-1:0]);
                w_mplr  = i_ki;
            end
            ST_MUL_DK: begin
                w_mcand = MC_W'(r_mag_d);
                w_mplr  = i_kd;
            end
            ST_MUL_DM: begin
                w_mcand = w_prod[MC_W-1:0];
                w_mplr  = ML_W'(MICRO);
            end
            ST_DIV_D: begin
                w_dvd  = DV_W'(w_prod[PR_W-1:16]);
                w_dvsr = i_dt;
            end
            default: begin
                w_mcand = '0;
            end
        endcase
    end

    tapv_mul u_mul (
        .i_clk   (i_clk),
        .i_load  (i_ctrl.mul_load),
        .i_step  (i_ctrl.mul_step),
        .i_mcand (w_mcand),
        .i_mplr  (w_mplr),
        .o_prod  (w_prod)
    );

    tapv_div u_div (
        .i_clk  (i_clk),
        .i_load (i_ctrl.div_load),
        .i_step (i_ctrl.div_step),
        .i_dvd  (w_dvd),
        .i_dvsr (w_dvsr),
        .o_quot (w_quot)
    );

    // Each term is a truncated magnitude that takes its sign only when it is added.
    always_comb begin
        w_term_p  = TOT_W'(w_prod[55:16]);
        w_term_i  = TOT_W'(w_prod[71:16]);
        w_term_d  = TOT_W'(w_quot[60:0]);
        w_sum_all = r_total + (r_neg_d ? (TOT_W'(0) - w_term_d) : w_term_d);
        if (!w_sum_all[TOT_W-1] && (|w_sum_all[TOT_W-2:VEL_W-1])) begin
            o_vel = {1'b0, {(VEL_W-1){1'b1}}};
        end else if (w_sum_all[TOT_W-1] && !(&w_sum_all[TOT_W-2:VEL_W-1])) begin
            o_vel = {1'b1, {(VEL_W-1){1'b0}}};
        end else begin
            o_vel = w_sum_all[VEL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_load && i_ctrl.state == ST_MUL_IS) begin
            r_total <= r_neg_e ? (TOT_W'(0) - w_term_p) : w_term_p;
        end else if (i_ctrl.mul_load && i_ctrl.state == ST_MUL_DK) begin
            r_total <= r_total + (r_neg_s ? (TOT_W'(0) - w_term_i) : w_term_i);
        end
    end

endmodule

[design/three_axis_pid_velocity.sv]
// Top level of the three-axis PID velocity block: registers, sequencer and lanes.
//
//  channel   direction  handshake                     payload
//  input     in         i_in_valid / o_in_ready       i_err_*, i_prev_err_*, i_step_us
//  result    out        o_out_valid / i_out_ready     o_vel_x, o_vel_y, o_vel_h
//  config    in         i_cfg_we                      i_cfg_idx, i_cfg_data
//
// An item passes, from one accepted transaction to the next, through five serial multiplies,
// two serial divides, a final state that sums and saturates, and the idle state in which the
// next transaction is taken; the divider produces one quotient bit per cycle.
// Reset clears the error sums, restores the gains and empties the result register.
// A stalled result holds the block in its final cycle only if the previous result is
// still waiting; otherwise the next transaction is taken while the result waits.
// A transaction with a zero step time is taken and dropped without a result.
module three_axis_pid_velocity
    import tapv_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [GAIN_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [ERR_W-1:0]     i_err_x,
    input  logic [ERR_W-1:0]     i_err_y,
    input  logic [ERR_W-1:0]     i_err_h,
    input  logic [ERR_W-1:0]     i_prev_err_x,
    input  logic [ERR_W-1:0]     i_prev_err_y,
    input  logic [ERR_W-1:0]     i_prev_err_h,
    input  logic [DT_W-1:0]      i_step_us,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [VEL_W-1:0]     o_vel_x,
    output logic [VEL_W-1:0]     o_vel_y,
    output logic [VEL_W-1:0]     o_vel_h
);

    logic [GAIN_W-1:0] r_kp;
    logic [GAIN_W-1:0] r_ki;
    logic [GAIN_W-1:0] r_kd;
    logic [DT_W-1:0]   r_dt;
    t_state            r_state;
    t_state            n_state;
    t_state            w_next;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic [CNT_W-1:0]  w_last;
    logic              w_is_mul;
    logic              w_is_div;
    logic              w_take;
    logic              w_fin_go;
    logic              r_out_valid;
    logic [VEL_W-1:0]  r_vel [AXES];
    logic [VEL_W-1:0]  w_vel [AXES];
    logic [ERR_W-1:0]  w_err [AXES];
    logic [ERR_W-1:0]  w_prev [AXES];
    t_ctrl             w_ctrl;

    assign w_err[0]  = i_err_x;
    assign w_err[1]  = i_err_y;
    assign w_err[2]  = i_err_h;
    assign w_prev[0] = i_prev_err_x;
    assign w_prev[1] = i_prev_err_y;
    assign w_prev[2] = i_prev_err_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= KP_RESET;
            r_ki <= KI_RESET;
            r_kd <= KD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GAIN_PROP:  r_kp <= i_cfg_data;
                CFG_GAIN_INTEG: r_ki <= i_cfg_data;
                CFG_GAIN_DERIV: r_kd <= i_cfg_data;
                default:        r_kp <= r_kp;
            endcase
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_take     = i_in_valid && o_in_ready && (i_step_us != '0);

    always_comb begin
        w_is_mul = 1'b0;
        w_is_div = 1'b0;
        w_next   = ST_IDLE;
        unique case (r_state) inside
            ST_MUL_P:  begin w_is_mul = 1'b1; w_next = ST_MUL_IS; end
            ST_MUL_IS: begin w_is_mul = 1'b1; w_next = ST_DIV_I;  end
            ST_DIV_I:  begin w_is_div = 1'b1; w_next = ST_MUL_IK; end
            ST_MUL_IK: begin w_is_mul = 1'b1; w_next = ST_MUL_DK; end
            ST_MUL_DK: begin w_is_mul = 1'b1; w_next = ST_MUL_DM; end
            ST_MUL_DM: begin w_is_mul = 1'b1; w_next = ST_DIV_D;  end
            ST_DIV_D:  begin w_is_div = 1'b1; w_next = ST_FIN;    end
            default:   begin w_next = ST_IDLE; end
        endcase
        w_last = w_is_mul ? CNT_W'(MUL_STEPS) : CNT_W'(DIV_STEPS);
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        w_fin_go = 1'b0;
        unique case (r_state) inside
            ST_IDLE: begin
                if (w_take) begin
                    n_state = ST_MUL_P;
                    n_cnt   = '0;
                end
            end
            ST_MUL_P, ST_MUL_IS, ST_DIV_I, ST_MUL_IK, ST_MUL_DK, ST_MUL_DM,
            ST_DIV_D: begin
                if (r_cnt == w_last) begin
                    n_state = w_next;
                    n_cnt   = '0;
                end else begin
                    n_cnt = CNT_W'(r_cnt + CNT_W'(1));
                end
            end
            ST_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state  = ST_IDLE;
                    w_fin_go = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (w_fin_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_dt <= i_step_us;
        end
    end

    always_comb begin
        w_ctrl.state    = r_state;
        w_ctrl.take     = w_take;
        w_ctrl.mul_load = w_is_mul && (r_cnt == '0);
        w_ctrl.mul_step = w_is_mul && (r_cnt != '0);
        w_ctrl.div_load = w_is_div && (r_cnt == '0);
        w_ctrl.div_step = w_is_div && (r_cnt != '0);
    end

    for (genvar g = 0; g < AXES; g++) begin : g_lane
        tapv_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl),
            .i_kp       (r_kp),
            .i_ki       (r_ki),
            .i_kd       (r_kd),
            .i_dt       (r_dt),
            .i_err      (w_err[g]),
            .i_prev_err (w_prev[g]),
            .o_vel      (w_vel[g])
        );

        always_ff @(posedge i_clk) begin
            if (w_fin_go) begin
                r_vel[g] <= w_vel[g];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_vel_x     = r_vel[0];
    assign o_vel_y     = r_vel[1];
    assign o_vel_h     = r_vel[2];

    a_take_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> (r_state == ST_MUL_P) && (r_cnt == '0))
        else $error("Accepted transaction did not start the first multiply.");

    a_zero_step_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_step_us == '0)) |=> (r_state == ST_IDLE))
        else $error("Transaction with zero step time was not dropped.");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_is_mul || w_is_div) |-> (r_cnt <= w_last))
        else $error("Phase counter ran past the end of its phase.");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_FIN))
        else $error("Result register filled outside the final cycle.");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_FIN) && r_out_valid && !i_out_ready) |=> (r_state == ST_FIN))
        else $error("Finished result left the final cycle while the output was full.");

endmodule
